>>> rtl/core/csv_fs_pkg.sv
// Package for the CSV field splitter: item structs, register indexes,
// quote mode encoding and character constants. No dependencies.
package csv_fs_pkg;

  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] REG_DELIMITER = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_QUOTE = 1'b1;

  localparam logic [7:0] DELIM_RESET = 8'd44;
  localparam logic [7:0] QUOTE_RESET = 8'd34;

  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_CR = 8'h0d;

  typedef enum logic [2:0] {
    MODE_UNQUOTED = 3'b001,
    MODE_QUOTED   = 3'b010,
    MODE_QSEEN    = 3'b100
  } quote_mode_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       field_end;
    logic       record_end;
    logic       input_end;
  } out_item_t;

  typedef struct packed {
    logic      has_result;
    out_item_t item;
  } step_res_t;

endpackage

>>> rtl/core/csv_fs_step.sv
// Parser state and per-character decode for the CSV field splitter.
// Depends on csv_fs_pkg.
module csv_fs_step (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  csv_fs_pkg::in_item_t  item,
  input  logic [7:0]            delimiter_char,
  input  logic [7:0]            quote_char,
  output csv_fs_pkg::step_res_t res
);
  import csv_fs_pkg::*;

  quote_mode_t mode, mode_next;
  logic        field_has_bytes, field_has_bytes_next;
  logic        swallow_lf, swallow_lf_next;

  logic [7:0] c;
  logic       is_lf, is_cr;

  assign c = item.char_in;
  assign is_lf = (c == CH_LF);
  assign is_cr = (c == CH_CR);

  always_comb begin
    mode_next = mode;
    field_has_bytes_next = field_has_bytes;
    swallow_lf_next = 1'b0;
    res = '0;
    priority if (item.end_of_input) begin
      mode_next = MODE_UNQUOTED;
      field_has_bytes_next = 1'b0;
      res.has_result = 1'b1;
      res.item.field_end = field_has_bytes;
      res.item.record_end = field_has_bytes;
      res.item.input_end = 1'b1;
    end else if (is_lf && swallow_lf) begin
      // drop the LF of a CR LF pair that already ended the record
    end else if (is_lf || is_cr) begin
      res.has_result = 1'b1;
      if (mode == MODE_QUOTED) begin
        field_has_bytes_next = 1'b1;
        res.item.data_byte = CH_LF;
        res.item.byte_valid = 1'b1;
      end else begin
        mode_next = MODE_UNQUOTED;
        field_has_bytes_next = 1'b0;
        swallow_lf_next = is_cr;
        res.item.field_end = 1'b1;
        res.item.record_end = 1'b1;
      end
    end else if (c == delimiter_char) begin
      res.has_result = 1'b1;
      if (mode == MODE_QUOTED) begin
        field_has_bytes_next = 1'b1;
        res.item.data_byte = c;
        res.item.byte_valid = 1'b1;
      end else begin
        mode_next = MODE_UNQUOTED;
        field_has_bytes_next = 1'b0;
        res.item.field_end = 1'b1;
      end
    end else if (c == quote_char) begin
      unique case (mode)
        MODE_UNQUOTED: mode_next = MODE_QUOTED;
        MODE_QUOTED:   mode_next = MODE_QSEEN;
        default: begin
          // doubled quote: emit one literal quote
          mode_next = MODE_QUOTED;
          field_has_bytes_next = 1'b1;
          res.has_result = 1'b1;
          res.item.data_byte = c;
          res.item.byte_valid = 1'b1;
        end
      endcase
    end else begin
      field_has_bytes_next = 1'b1;
      res.has_result = 1'b1;
      res.item.data_byte = c;
      res.item.byte_valid = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_UNQUOTED;
      field_has_bytes <= 1'b0;
      swallow_lf <= 1'b0;
    end else if (adv) begin
      mode <= mode_next;
      field_has_bytes <= field_has_bytes_next;
      swallow_lf <= swallow_lf_next;
    end
  end

endmodule

>>> rtl/core/csv_field_splitter.sv
// Top level of the CSV field splitter: input register, config registers,
// parser step and output register. Depends on csv_fs_pkg and csv_fs_step.
//
//   port group   dir  handshake              payload
//   in_*         in   in_valid / in_ready    in_item  (char_in, end_of_input)
//   out_*        out  out_valid / out_ready  out_item (data_byte .. input_end)
//   cfg_*        in   cfg_wr_en              cfg_index, cfg_wdata
//
// One item per cycle sustained while the output is not stalled; an item passes the
// input register, then the output register. The limit is the parser state update,
// a handful of byte compares per cycle. An item that yields no result (a quote, a
// swallowed LF) still takes its slot. Synchronous reset clears the parser state and
// valid flags and loads the config registers with their defaults.
// A stalled output holds its item; the input register takes an item while it is empty
// or while the output register can drain.
module csv_field_splitter (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  csv_fs_pkg::in_item_t                 in_item,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output csv_fs_pkg::out_item_t                out_item,
  input  logic                                 cfg_wr_en,
  input  logic [csv_fs_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [csv_fs_pkg::CfgDataW-1:0]      cfg_wdata
);
  import csv_fs_pkg::*;

  logic       s1_valid;
  in_item_t   s1_item;
  logic       adv;
  logic       out_free;
  step_res_t  res;
  logic [7:0] delimiter_char;
  logic [7:0] quote_char;

  assign out_free = !out_valid || out_ready;
  assign adv = s1_valid && out_free;
  assign in_ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter_char <= DELIM_RESET;
      quote_char <= QUOTE_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_DELIMITER: delimiter_char <= cfg_wdata;
        REG_QUOTE:     quote_char <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item <= in_item;
    end
  end

  csv_fs_step u_step (
    .clk            (clk),
    .rst            (rst),
    .adv            (adv),
    .item           (s1_item),
    .delimiter_char (delimiter_char),
    .quote_char     (quote_char),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= adv && res.has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.has_result) begin
      out_item <= res.item;
    end
  end

  a_accept_fills_stage : assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> s1_valid)
    else $error("accepted item did not reach the input register");

  a_record_has_field : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.record_end |-> out_item.field_end)
    else $error("record end without field end");

  a_byte_alone : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.byte_valid |->
      !out_item.field_end && !out_item.input_end)
    else $error("data byte combined with a mark");

  a_idle_byte_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.byte_valid |-> out_item.data_byte == 8'd0)
    else $error("data byte not cleared in a mark item");

endmodule
